// ===== src/mfb_pkg.sv =====
// Shared types, defaults and sizing helpers for the monochrome framebuffer bar drawer.
`default_nettype none

package mfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 32;
  localparam int BYTE_ADDR_W       = 9;

  typedef enum logic [2:0] {
    FN_PIXEL = 3'd0,
    FN_HBAR  = 3'd1,
    FN_VBAR  = 3'd2,
    FN_CLEAR = 3'd3,
    FN_READ  = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] end_pos;
    logic [7:0] thickness;
    logic       pixel_on;
  } mfb_draw_t;

  function automatic int mfb_pages(input int h);
    return (h + 7) >> 3;
  endfunction

  function automatic int mfb_col_w(input int w);
    return $clog2(w);
  endfunction

  function automatic int mfb_pg_w(input int h);
    return (mfb_pages(h) > 1) ? $clog2(mfb_pages(h)) : 1;
  endfunction

  function automatic int mfb_addr_w(input int w, input int h);
    return $clog2(w * mfb_pages(h));
  endfunction

endpackage

`default_nettype wire

// ===== src/mono_framebuffer_bar_draw.sv =====
// Top level: monochrome page-organized framebuffer with pixel, bar, clear and read ops.
//
//   channel | direction | handshake           | fields
//   --------+-----------+---------------------+--------------------------------------------
//   in      | to block  | in_valid / in_stall | func x_pos y_pos end_pos thickness
//           |           |                     | pixel_on byte_addr
//   out     | from block| out_valid/out_stall | read_byte
//
// Pixel and read ops that touch the store pass through ST_RD and ST_WR; ops that touch
// nothing (off-screen pixel, empty bar, read past the store, spare codes) skip both.
// A bar does one ST_RD/ST_WR pass per store byte it spans
// (hbar: columns x..end-1 times all pages; vbar: all columns times pages spanned);
// clear writes zero to all SCREEN_WIDTH*pages bytes through the single store write port.
// After reset the store is swept to zero, one byte a cycle, with in_stall high. One output
// register holds a finished word so the next op can start while out_stall is high.
`default_nettype none

module mono_framebuffer_bar_draw
  import mfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [2:0]             func,
  input  wire logic [7:0]             x_pos,
  input  wire logic [7:0]             y_pos,
  input  wire logic [7:0]             end_pos,
  input  wire logic [7:0]             thickness,
  input  wire logic                   pixel_on,
  input  wire logic [BYTE_ADDR_W-1:0] byte_addr,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  read_byte
);

  localparam int STORE_BYTES = SCREEN_WIDTH * mfb_pages(SCREEN_HEIGHT);
  localparam int ADDR_W      = mfb_addr_w(SCREEN_WIDTH, SCREEN_HEIGHT);

  logic              done_valid;
  logic              done_ready;
  logic [7:0]        result;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  mfb_store #(
    .DEPTH (STORE_BYTES),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  mfb_seq #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .end_pos   (end_pos),
    .thickness (thickness),
    .pixel_on  (pixel_on),
    .byte_addr (byte_addr),
    .done_valid(done_valid),
    .done_ready(done_ready),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output slot is free when empty or being drained this cycle
  assign done_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_valid && done_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      read_byte <= result;
    end
  end

endmodule

`default_nettype wire

// ===== src/mfb_store.sv =====
// Frame store: one write port, one registered read port.
`default_nettype none

module mfb_store
  import mfb_pkg::*;
#(
  parameter int DEPTH  = SCREEN_WIDTH_DEF * 4,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/mfb_mask.sv =====
// Per-byte coverage mask and merge for pixel and bar operations.
`default_nettype none

module mfb_mask
  import mfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int COL_W         = mfb_col_w(SCREEN_WIDTH),
  parameter int PG_W          = mfb_pg_w(SCREEN_HEIGHT)
) (
  input  wire mfb_draw_t        draw,
  input  wire logic [COL_W-1:0] col,
  input  wire logic [PG_W-1:0]  page,
  input  wire logic [7:0]       old_byte,
  output logic      [7:0]       new_byte
);

  logic [7:0] col8;
  logic       col_hbar;
  logic       col_vbar;
  logic       col_pix;
  logic [7:0] mask;
  logic       set_val;

  assign col8     = 8'(col);
  assign col_hbar = (col8 >= draw.x_pos) && (col8 < draw.end_pos);
  // thickness run starting at x_pos, wrapping at 256
  assign col_vbar = 8'(col8 - draw.x_pos) < draw.thickness;
  assign col_pix  = (col8 == draw.x_pos);

  for (genvar b = 0; b < 8; b++) begin : g_bit
    logic [7:0] row;
    logic       on_screen;
    logic       row_hbar;
    logic       row_vbar;
    logic       row_pix;

    assign row       = 8'({page, 3'(b)});
    assign on_screen = {1'b0, row} < 9'(SCREEN_HEIGHT);
    assign row_hbar  = 8'(row - draw.y_pos) < draw.thickness;
    assign row_vbar  = (row >= draw.y_pos) && (row < draw.end_pos);
    assign row_pix   = (row == draw.y_pos);

    always_comb begin
      unique case (draw.func)
        FN_PIXEL: mask[b] = on_screen && col_pix && row_pix;
        FN_HBAR:  mask[b] = on_screen && col_hbar && row_hbar;
        FN_VBAR:  mask[b] = on_screen && col_vbar && row_vbar;
        default:  mask[b] = 1'b0;
      endcase
    end
  end

  assign set_val  = (draw.func == FN_PIXEL) ? draw.pixel_on : 1'b1;
  assign new_byte = set_val ? (old_byte | mask) : (old_byte & ~mask);

endmodule

`default_nettype wire

// ===== src/mfb_seq.sv =====
// Sequencer: walks touched bytes; read-modify-write for draws, zero-fill for clear.
`default_nettype none

module mfb_seq
  import mfb_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int ADDR_W        = mfb_addr_w(SCREEN_WIDTH, SCREEN_HEIGHT)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [2:0]             func,
  input  wire logic [7:0]             x_pos,
  input  wire logic [7:0]             y_pos,
  input  wire logic [7:0]             end_pos,
  input  wire logic [7:0]             thickness,
  input  wire logic                   pixel_on,
  input  wire logic [BYTE_ADDR_W-1:0] byte_addr,
  output logic                        done_valid,
  input  wire logic                   done_ready,
  output logic [7:0]                  result,
  output logic                        mem_we,
  output logic [ADDR_W-1:0]           mem_waddr,
  output logic [7:0]                  mem_wdata,
  output logic                        mem_re,
  output logic [ADDR_W-1:0]           mem_raddr,
  input  wire logic [7:0]             mem_rdata
);

  localparam int PAGES       = mfb_pages(SCREEN_HEIGHT);
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int COL_W       = mfb_col_w(SCREEN_WIDTH);
  localparam int PG_W        = mfb_pg_w(SCREEN_HEIGHT);

  state_t            state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [COL_W-1:0]  col_lo, col_lo_next;
  logic [COL_W-1:0]  col_hi, col_hi_next;
  logic [PG_W-1:0]   page, page_next;
  logic [PG_W-1:0]   page_hi, page_hi_next;
  mfb_draw_t         op, op_next;
  logic [ADDR_W-1:0] rd_addr, rd_addr_next;
  logic [7:0]        result_next;

  logic [ADDR_W-1:0] byte_idx;
  logic              last;
  logic [7:0]        merged;
  logic [8:0]        end_cl;
  logic [8:0]        end_rl;
  func_t             func_in;

  assign byte_idx = ADDR_W'(col) + ADDR_W'(ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH));
  assign last     = (col == col_hi) && (page == page_hi);
  assign end_cl   = ({1'b0, end_pos} < 9'(SCREEN_WIDTH)) ? {1'b0, end_pos} : 9'(SCREEN_WIDTH);
  assign end_rl   = ({1'b0, end_pos} < 9'(SCREEN_HEIGHT)) ? {1'b0, end_pos}
                                                          : 9'(SCREEN_HEIGHT);
  assign func_in  = func_t'(func);

  assign mem_waddr = byte_idx;
  assign mem_raddr = (op.func == FN_READ) ? rd_addr : byte_idx;

  mfb_mask #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .COL_W        (COL_W),
    .PG_W         (PG_W)
  ) u_mask (
    .draw    (op),
    .col     (col),
    .page    (page),
    .old_byte(mem_rdata),
    .new_byte(merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      col     <= '0;
      col_lo  <= '0;
      col_hi  <= COL_W'(SCREEN_WIDTH - 1);
      page    <= '0;
      page_hi <= PG_W'(PAGES - 1);
    end else begin
      state   <= state_next;
      col     <= col_next;
      col_lo  <= col_lo_next;
      col_hi  <= col_hi_next;
      page    <= page_next;
      page_hi <= page_hi_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    rd_addr <= rd_addr_next;
    result  <= result_next;
  end

  always_comb begin
    state_next   = state;
    col_next     = col;
    col_lo_next  = col_lo;
    col_hi_next  = col_hi;
    page_next    = page;
    page_hi_next = page_hi;
    op_next      = op;
    rd_addr_next = rd_addr;
    result_next  = result;
    in_stall     = 1'b1;
    done_valid   = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = merged;
    mem_re       = 1'b0;

    unique case (state)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (last) begin
          state_next = (state == ST_INIT) ? ST_IDLE : ST_DONE;
        end else if (col == col_hi) begin
          col_next  = col_lo;
          page_next = PG_W'(page + 1'b1);
        end else begin
          col_next = COL_W'(col + 1'b1);
        end
      end

      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_next      = '{func: func_in, x_pos: x_pos, y_pos: y_pos, end_pos: end_pos,
                           thickness: thickness, pixel_on: pixel_on};
          result_next  = '0;
          state_next   = ST_DONE;
          unique case (func_in)
            FN_PIXEL: begin
              if (({1'b0, x_pos} < 9'(SCREEN_WIDTH)) && ({1'b0, y_pos} < 9'(SCREEN_HEIGHT))) begin
                col_next     = COL_W'(x_pos);
                col_lo_next  = COL_W'(x_pos);
                col_hi_next  = COL_W'(x_pos);
                page_next    = PG_W'(y_pos >> 3);
                page_hi_next = PG_W'(y_pos >> 3);
                state_next   = ST_RD;
              end
            end
            FN_HBAR: begin
              if (({1'b0, x_pos} < end_cl) && (thickness != 8'd0)) begin
                col_next     = COL_W'(x_pos);
                col_lo_next  = COL_W'(x_pos);
                col_hi_next  = COL_W'(end_cl - 9'd1);
                page_next    = '0;
                page_hi_next = PG_W'(PAGES - 1);
                state_next   = ST_RD;
              end
            end
            FN_VBAR: begin
              // every column is visited since the thickness run may wrap
              if (({1'b0, y_pos} < end_rl) && (thickness != 8'd0)) begin
                col_next     = '0;
                col_lo_next  = '0;
                col_hi_next  = COL_W'(SCREEN_WIDTH - 1);
                page_next    = PG_W'(y_pos >> 3);
                page_hi_next = PG_W'((end_rl - 9'd1) >> 3);
                state_next   = ST_RD;
              end
            end
            FN_CLEAR: begin
              col_next     = '0;
              col_lo_next  = '0;
              col_hi_next  = COL_W'(SCREEN_WIDTH - 1);
              page_next    = '0;
              page_hi_next = PG_W'(PAGES - 1);
              state_next   = ST_CLEAR;
            end
            FN_READ: begin
              if (32'(byte_addr) < 32'(STORE_BYTES)) begin
                rd_addr_next = ADDR_W'(byte_addr);
                state_next   = ST_RD;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_RD: begin
        mem_re     = 1'b1;
        state_next = ST_WR;
      end

      ST_WR: begin
        if (op.func == FN_READ) begin
          result_next = mem_rdata;
          state_next  = ST_DONE;
        end else begin
          mem_we = 1'b1;
          if (last) begin
            state_next = ST_DONE;
          end else if (col == col_hi) begin
            col_next   = col_lo;
            page_next  = PG_W'(page + 1'b1);
            state_next = ST_RD;
          end else begin
            col_next   = COL_W'(col + 1'b1);
            state_next = ST_RD;
          end
        end
      end

      ST_DONE: begin
        done_valid = 1'b1;
        if (done_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_waddr_in_store: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < 32'(STORE_BYTES)))
    else $error("write beyond frame store");

  a_walk_in_bounds: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RD || state == ST_WR) && op.func != FN_READ)
      |-> (col <= col_hi && page <= page_hi))
    else $error("byte walk left its range");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (done_valid && !done_ready) |=> (done_valid && $stable(result)))
    else $error("finished word changed while waiting");

  a_no_write_when_open: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> (!mem_we && !mem_re))
    else $error("store access while taking a new word");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_mono_framebuffer_bar_draw.sv =====
// Self-checking testbench for the monochrome framebuffer bar drawer.
`timescale 1ns / 1ps

module tb_mono_framebuffer_bar_draw;
  import mfb_pkg::*;

  localparam int SCR_W        = SCREEN_WIDTH_DEF;
  localparam int SCR_H        = SCREEN_HEIGHT_DEF;
  localparam int PAGES        = (SCR_H + 7) / 8;
  localparam int STORE_BYTES  = SCR_W * PAGES;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]             func;
    logic [7:0]             x_pos;
    logic [7:0]             y_pos;
    logic [7:0]             end_pos;
    logic [7:0]             thickness;
    logic                   pixel_on;
    logic [BYTE_ADDR_W-1:0] byte_addr;
  } draw_req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [2:0]             func = '0;
  logic [7:0]             x_pos = '0;
  logic [7:0]             y_pos = '0;
  logic [7:0]             end_pos = '0;
  logic [7:0]             thickness = '0;
  logic                   pixel_on = 1'b0;
  logic [BYTE_ADDR_W-1:0] byte_addr = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             read_byte;

  // shadow copy of the frame store and the bytes still owed by the block
  bit   [7:0] shadow_fb [STORE_BYTES];
  logic [7:0] exp_bytes [$];

  int tx_gap_max = 6;
  int rx_gap_max = 6;
  int hold_req = 0;
  int hold_left = 0;
  int rx_wait_left = 0;
  int idle_cycles = 0;
  int err_count = 0;
  int words_sent = 0;
  int bytes_checked = 0;
  int op_count [8];

  mono_framebuffer_bar_draw dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .end_pos   (end_pos),
    .thickness (thickness),
    .pixel_on  (pixel_on),
    .byte_addr (byte_addr),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_byte (read_byte)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void plot(int col, int row, bit on);
    int idx;
    if (col >= SCR_W || row >= SCR_H) return;
    idx = col + (row >> 3) * SCR_W;
    if (idx >= STORE_BYTES) return;
    shadow_fb[idx][row % 8] = on;
  endfunction

  // applies one word to the shadow store, returns the byte the block should emit
  function automatic logic [7:0] predict_byte(draw_req_t r);
    logic [7:0] res;
    int a;
    int i;
    res = '0;
    case (r.func)
      FN_PIXEL: plot(int'(r.x_pos), int'(r.y_pos), r.pixel_on);
      FN_HBAR: begin
        for (a = int'(r.x_pos); a < int'(r.end_pos); a++)
          for (i = 0; i < int'(r.thickness); i++)
            plot(a, (int'(r.y_pos) + i) & 255, 1'b1);
      end
      FN_VBAR: begin
        for (a = int'(r.y_pos); a < int'(r.end_pos); a++)
          for (i = 0; i < int'(r.thickness); i++)
            plot((int'(r.x_pos) + i) & 255, a, 1'b1);
      end
      FN_CLEAR: begin
        foreach (shadow_fb[k]) shadow_fb[k] = '0;
      end
      FN_READ: begin
        if (r.byte_addr < STORE_BYTES) res = shadow_fb[r.byte_addr];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic draw_req_t mk(logic [2:0] f, int x, int y, int e, int t, bit on,
                                   int addr);
    draw_req_t r;
    r.func      = f;
    r.x_pos     = 8'(x);
    r.y_pos     = 8'(y);
    r.end_pos   = 8'(e);
    r.thickness = 8'(t);
    r.pixel_on  = on;
    r.byte_addr = BYTE_ADDR_W'(addr);
    return r;
  endfunction

  function automatic draw_req_t rand_draw();
    draw_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r = mk(FN_READ, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 255), 1'($urandom_range(0, 1)), $urandom_range(0, 511));
    if (pick < 30) begin
      r.func = FN_PIXEL;
      if (pick < 26) begin
        r.x_pos = 8'($urandom_range(0, SCR_W - 1));
        r.y_pos = 8'($urandom_range(0, SCR_H - 1));
      end
    end else if (pick < 42) begin
      r.func = FN_HBAR;
      if (pick < 40) begin
        r.x_pos   = 8'($urandom_range(0, SCR_W - 1));
        r.end_pos = r.x_pos + 8'($urandom_range(0, 12));
        if (pick < 37) begin
          r.y_pos     = 8'($urandom_range(0, SCR_H - 1));
          r.thickness = 8'($urandom_range(0, 12));
        end else begin
          // rows run past 255 and wrap back onto the top of the screen
          r.y_pos     = 8'($urandom_range(224, 255));
          r.thickness = 8'($urandom_range(0, 48));
        end
      end
    end else if (pick < 52) begin
      r.func = FN_VBAR;
      if (pick < 50) begin
        r.y_pos   = 8'($urandom_range(0, SCR_H - 1));
        r.end_pos = r.y_pos + 8'($urandom_range(0, 10));
        if (pick < 48) begin
          r.x_pos     = 8'($urandom_range(0, SCR_W - 1));
          r.thickness = 8'($urandom_range(0, 10));
        end else begin
          r.x_pos     = 8'($urandom_range(240, 255));
          r.thickness = 8'($urandom_range(0, 24));
        end
      end
    end else if (pick < 54) begin
      r.func = FN_CLEAR;
    end else if (pick >= 97) begin
      r.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    end
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the word was taken
  task automatic send_word(draw_req_t r);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= r.func;
    x_pos     <= r.x_pos;
    y_pos     <= r.y_pos;
    end_pos   <= r.end_pos;
    thickness <= r.thickness;
    pixel_on  <= r.pixel_on;
    byte_addr <= r.byte_addr;
    do @(posedge clk); while (in_stall);
    exp_bytes.push_back(predict_byte(r));
    words_sent++;
    op_count[r.func]++;
  endtask

  function automatic void flag_error(string what, logic [7:0] want, logic [7:0] got);
    err_count++;
    if (err_count <= 10)
      $display("ERROR word %0d: %s, expected %02h got %02h", bytes_checked, what, want, got);
  endfunction

  task automatic test_directed();
    draw_req_t seq [$];
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 0));
    seq.push_back(mk(FN_PIXEL, 0, 0, 0, 0, 1, 0));
    seq.push_back(mk(FN_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, 1, 0));
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 0));
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 511));
    seq.push_back(mk(FN_PIXEL, 0, 0, 0, 0, 0, 0));
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 0));
    // off-screen pixels are dropped
    seq.push_back(mk(FN_PIXEL, SCR_W, 5, 0, 0, 1, 0));
    seq.push_back(mk(FN_PIXEL, 255, 255, 255, 255, 1, 511));
    seq.push_back(mk(FN_PIXEL, 3, SCR_H, 0, 0, 1, 0));
    seq.push_back(mk(FN_HBAR, 0, 8, SCR_W, 8, 0, 0));
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, SCR_W + 5));
    seq.push_back(mk(FN_HBAR, 10, 250, 20, 10, 0, 0));
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 15));
    // empty bars: no span, zero thickness, end before start
    seq.push_back(mk(FN_HBAR, 40, 0, 40, 5, 0, 0));
    seq.push_back(mk(FN_HBAR, 50, 0, 60, 0, 0, 0));
    seq.push_back(mk(FN_HBAR, 60, 0, 50, 5, 0, 0));
    seq.push_back(mk(FN_VBAR, 254, 16, 24, 4, 0, 0));
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 2 * SCR_W + 1));
    seq.push_back(mk(FN_VBAR, 100, 20, 255, 1, 0, 0));
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 3 * SCR_W + 100));
    seq.push_back(mk(FN_SPARE_LO, 255, 255, 255, 255, 1, 511));
    seq.push_back(mk(FN_SPARE_HI, 0, 0, 0, 0, 0, 0));
    seq.push_back(mk(FN_HBAR, 0, 0, 255, 255, 1, 511));
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 300));
    seq.push_back(mk(FN_CLEAR, 0, 0, 0, 0, 0, 0));
    seq.push_back(mk(FN_READ, 0, 0, 0, 0, 0, 300));
    foreach (seq[i]) send_word(seq[i]);
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      // every fourth stretch of 100 words runs with no idling on either side
      tx_gap_max = ((i / 100) % 4 == 3) ? 0 : 6;
      rx_gap_max = tx_gap_max;
      send_word(rand_draw());
    end
  endtask

  // pixel write immediately followed by a read of the byte holding it
  task automatic test_back_to_back(int pairs);
    draw_req_t r;
    tx_gap_max = 0;
    rx_gap_max = 0;
    for (int i = 0; i < pairs; i++) begin
      r = rand_draw();
      r.func  = FN_PIXEL;
      r.x_pos = 8'($urandom_range(0, SCR_W - 1));
      r.y_pos = 8'($urandom_range(0, SCR_H - 1));
      send_word(r);
      r.func      = FN_READ;
      r.byte_addr = BYTE_ADDR_W'(int'(r.x_pos) + int'(r.y_pos >> 3) * SCR_W);
      send_word(r);
    end
  endtask

  // receiver holds off while words keep coming, so the block backs up its input
  task automatic test_output_hold(int count);
    draw_req_t r;
    tx_gap_max = 0;
    rx_gap_max = 6;
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < count; i++) begin
      r = rand_draw();
      if (r.func != FN_PIXEL) r.func = FN_READ;
      send_word(r);
    end
  endtask

  // receiver: random stall after each word, plus the long hold on request
  always @(posedge clk) begin
    logic stall_nxt;
    stall_nxt = 1'b0;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_nxt = 1'b1;
    end else if (!rst) begin
      if (out_valid && !out_stall) rx_wait_left = $urandom_range(0, rx_gap_max);
      if (rx_wait_left > 0) begin
        rx_wait_left--;
        stall_nxt = 1'b1;
      end
    end
    out_stall <= stall_nxt;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (exp_bytes.size() == 0) begin
        flag_error("word with nothing outstanding", 8'h00, read_byte);
      end else begin
        logic [7:0] want;
        want = exp_bytes.pop_front();
        if (read_byte !== want) flag_error("read_byte mismatch", want, read_byte);
      end
      bytes_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("FAIL mono_framebuffer_bar_draw");
        $finish;
      end
    end
  end

  initial begin
    foreach (op_count[i]) op_count[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(900);
    test_back_to_back(50);
    test_output_hold(40);
    in_valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d words: pixel %0d, hbar %0d, vbar %0d, clear %0d, read %0d, spare %0d",
             words_sent, op_count[FN_PIXEL], op_count[FN_HBAR], op_count[FN_VBAR],
             op_count[FN_CLEAR], op_count[FN_READ],
             op_count[5] + op_count[6] + op_count[7]);
    $display("checked %0d output words, %0d mismatches", bytes_checked, err_count);
    if (err_count == 0 && exp_bytes.size() == 0) begin
      $display("PASS mono_framebuffer_bar_draw");
    end else begin
      $display("FAIL mono_framebuffer_bar_draw");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mfb_pkg.sv
src/mfb_store.sv
src/mfb_mask.sv
src/mfb_seq.sv
src/mono_framebuffer_bar_draw.sv
tb/sv/tb_mono_framebuffer_bar_draw.sv
